@@ hdl/assert_macros.svh @@
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, off while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

@@ hdl/m32se_pkg.sv @@
package m32se_pkg;

	localparam logic [31:0] TEXT_START = 32'h0040_0000;

	localparam int DATA_WORDS = 1024;
	localparam int DATA_AW    = $clog2(DATA_WORDS);

	// primary opcodes
	localparam logic [5:0] OP_SPECIAL = 6'd0;
	localparam logic [5:0] OP_J       = 6'd2;
	localparam logic [5:0] OP_JAL     = 6'd3;
	localparam logic [5:0] OP_BEQ     = 6'd4;
	localparam logic [5:0] OP_BNE     = 6'd5;
	localparam logic [5:0] OP_ADDIU   = 6'b001001;
	localparam logic [5:0] OP_SLTIU   = 6'b001011;
	localparam logic [5:0] OP_ANDI    = 6'd12;
	localparam logic [5:0] OP_ORI     = 6'd13;
	localparam logic [5:0] OP_LUI     = 6'd15;
	localparam logic [5:0] OP_LW      = 6'b100011;
	localparam logic [5:0] OP_SW      = 6'b101011;

	// function codes under the special opcode
	localparam logic [5:0] FN_SLL  = 6'd0;
	localparam logic [5:0] FN_SRL  = 6'd2;
	localparam logic [5:0] FN_JR   = 6'd8;
	localparam logic [5:0] FN_ADDU = 6'd33;
	localparam logic [5:0] FN_SUBU = 6'd35;
	localparam logic [5:0] FN_AND  = 6'd36;
	localparam logic [5:0] FN_OR   = 6'd37;
	localparam logic [5:0] FN_NOR  = 6'd39;
	localparam logic [5:0] FN_SLTU = 6'd43;

	localparam logic [4:0] REG_ZERO = 5'd0;
	localparam logic [4:0] REG_RA   = 5'd31;

	typedef struct packed {
		logic        wr;
		logic [4:0]  idx;
		logic [31:0] data;
	} rf_wr_t;

	typedef struct packed {
		logic               wr;
		logic               rd;
		logic [DATA_AW-1:0] addr;
		logic [31:0]        wdata;
	} dmem_req_t;

endpackage

@@ hdl/m32se_regfile.sv @@
module m32se_regfile (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [4:0]        rd_idx_a,
	input  logic [4:0]        rd_idx_b,
	input  m32se_pkg::rf_wr_t wr,
	output logic [31:0]       rd_data_a,
	output logic [31:0]       rd_data_b
);
	import m32se_pkg::*;

	logic [31:0] mem_q [32];
	logic [31:0] vld_q;
	logic [31:0] rdata_a_q;
	logic [31:0] rdata_b_q;
	logic [31:0] rd_a;
	logic [31:0] rd_b;

	// a write in the same cycle passes straight to the read data
	always_comb begin
		rd_a = vld_q[rd_idx_a] ? mem_q[rd_idx_a] : '0;
		rd_b = vld_q[rd_idx_b] ? mem_q[rd_idx_b] : '0;
		if (wr.wr && wr.idx == rd_idx_a) begin
			rd_a = wr.data;
		end
		if (wr.wr && wr.idx == rd_idx_b) begin
			rd_b = wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.wr) begin
			vld_q[wr.idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.wr) begin
			mem_q[wr.idx] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_a_q <= rd_a;
			rdata_b_q <= rd_b;
		end
	end

	assign rd_data_a = rdata_a_q;
	assign rd_data_b = rdata_b_q;

endmodule

@@ hdl/m32se_dstore.sv @@
module m32se_dstore (
	input  logic                 clk,
	input  logic                 arst_n,
	input  m32se_pkg::dmem_req_t req,
	output logic [31:0]          rdata,
	output logic                 busy
);
	import m32se_pkg::*;

	localparam logic [DATA_AW:0] CLR_END = (DATA_AW + 1)'(DATA_WORDS);

	logic [31:0]      mem_q [DATA_WORDS];
	logic [31:0]      rdata_q;
	logic [DATA_AW:0] clr_q;

	assign busy = (clr_q != CLR_END);

	// zeroing sweep after reset, one word per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (busy) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (busy) begin
			mem_q[clr_q[DATA_AW-1:0]] <= '0;
		end else if (req.wr) begin
			mem_q[req.addr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd) begin
			rdata_q <= mem_q[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/mips32_subset_execute.sv @@
// channel   direction  handshake              payload
// in        input      in_valid / in_stall    instr_word
// out       output     out_valid / out_stall  next_pc .. unsupported (nine fields)
// cfg       input      cfg_valid / cfg_ready  instruction_count
//
// two-stage pipe: operand read into s1, execute and data access into s2 (result register).
// one instruction per cycle sustained unless out_stall or the data-store clear holds the pipe.
// after reset the 1024 words of the data store are zeroed; in_stall is high meanwhile.
// a stalled result holds s2; s1 still takes one more instruction behind it.
// cfg_ready is always high.
`include "assert_macros.svh"

module mips32_subset_execute (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] instr_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] next_pc,
	output logic        reg_written,
	output logic [4:0]  reg_index,
	output logic [31:0] reg_value,
	output logic        store_done,
	output logic [31:0] store_addr,
	output logic [31:0] store_data,
	output logic        halted,
	output logic        unsupported,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] instruction_count
);
	import m32se_pkg::*;

	logic        in_xfer;
	logic        fire1;
	logic        s2_free;
	logic        clr_busy;

	logic        valid_s1;
	logic [31:0] instr_s1;
	logic        valid_s2;

	logic [31:0] pc_q;
	logic        halt_q;
	logic [15:0] ic_q;

	logic [31:0] rf_a;
	logic [31:0] rf_b;
	rf_wr_t      rf_wr;
	dmem_req_t   dm_req;
	logic [31:0] dm_rdata;

	// s2 payload
	logic [31:0] npc_s2;
	logic        wr_s2;
	logic [4:0]  idx_s2;
	logic [31:0] val_s2;
	logic        ld_s2;
	logic        st_s2;
	logic [31:0] saddr_s2;
	logic [31:0] sdata_s2;
	logic        halt_s2;
	logic        bad_s2;
	logic [31:0] wval_s2;

	// decode and execute of s1
	logic [5:0]  op;
	logic [5:0]  fn;
	logic [4:0]  rs;
	logic [4:0]  rt;
	logic [4:0]  rd;
	logic [4:0]  sh;
	logic [31:0] imm;
	logic [31:0] simm;
	logic [31:0] a;
	logic [31:0] b;
	logic [31:0] pc4;
	logic [31:0] br_tgt;
	logic [31:0] j_tgt;
	logic [31:0] eaddr;
	logic [31:0] halt_pc;
	logic [31:0] npc;
	logic        wr;
	logic [4:0]  dst;
	logic [31:0] val;
	logic        st;
	logic        ld;
	logic        bad;
	logic        halt_nx;

	assign s2_free   = !valid_s2 || !out_stall;
	assign fire1     = valid_s1 && s2_free;
	assign in_stall  = clr_busy || (valid_s1 && !s2_free);
	assign in_xfer   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign op   = instr_s1[31:26];
	assign fn   = instr_s1[5:0];
	assign rs   = instr_s1[25:21];
	assign rt   = instr_s1[20:16];
	assign rd   = instr_s1[15:11];
	assign sh   = instr_s1[10:6];
	assign imm  = {16'b0, instr_s1[15:0]};
	assign simm = {{16{instr_s1[15]}}, instr_s1[15:0]};

	// load data comes out of the store while its instruction sits in s2
	assign wval_s2 = ld_s2 ? dm_rdata : val_s2;

	// forward the result still in s2 over the register file read
	assign a = (valid_s2 && wr_s2 && idx_s2 == rs) ? wval_s2 : rf_a;
	assign b = (valid_s2 && wr_s2 && idx_s2 == rt) ? wval_s2 : rf_b;

	assign pc4     = pc_q + 32'd4;
	assign br_tgt  = pc4 + {simm[29:0], 2'b00};
	assign j_tgt   = {pc_q[31:28], instr_s1[25:0], 2'b00};
	assign eaddr   = a + simm;
	assign halt_pc = TEXT_START + {14'b0, ic_q, 2'b00};

	always_comb begin
		npc = pc4;
		wr  = 1'b0;
		dst = rt;
		val = '0;
		st  = 1'b0;
		ld  = 1'b0;
		bad = 1'b0;
		if (op == OP_SPECIAL) begin
			wr  = 1'b1;
			dst = rd;
			case (fn)
				FN_AND:  val = a & b;
				FN_ADDU: val = a + b;
				FN_NOR:  val = ~(a | b);
				FN_OR:   val = a | b;
				FN_SLTU: val = {31'b0, a < b};
				FN_SLL:  val = b << sh;
				FN_SRL:  val = b >> sh;
				FN_SUBU: val = a - b;
				FN_JR: begin
					wr  = 1'b0;
					npc = a;
				end
				default: begin
					wr  = 1'b0;
					bad = 1'b1;
				end
			endcase
		end else begin
			case (op)
				OP_J:     npc = j_tgt;
				OP_JAL: begin
					wr  = 1'b1;
					dst = REG_RA;
					val = pc_q + 32'd8;
					npc = j_tgt;
				end
				OP_ADDIU: begin
					wr  = 1'b1;
					val = a + simm;
				end
				OP_ANDI: begin
					wr  = 1'b1;
					val = a & imm;
				end
				OP_ORI: begin
					wr  = 1'b1;
					val = a | imm;
				end
				OP_LUI: begin
					wr  = 1'b1;
					val = {instr_s1[15:0], 16'b0};
				end
				OP_SLTIU: begin
					wr  = 1'b1;
					val = {31'b0, a < simm};
				end
				OP_LW: begin
					wr = 1'b1;
					ld = 1'b1;
				end
				OP_BEQ: begin
					if (a == b) begin
						npc = br_tgt;
					end
				end
				OP_BNE: begin
					if (a != b) begin
						npc = br_tgt;
					end
				end
				OP_SW:    st = 1'b1;
				default:  bad = 1'b1;
			endcase
		end
		if (bad) begin
			npc = pc_q;
			wr  = 1'b0;
			st  = 1'b0;
		end
		if (dst == REG_ZERO) begin
			wr = 1'b0;
		end
		ld = ld && wr;
		halt_nx = (npc == halt_pc);
		// once halted nothing executes
		if (halt_q) begin
			npc     = pc_q;
			wr      = 1'b0;
			st      = 1'b0;
			ld      = 1'b0;
			bad     = 1'b0;
			halt_nx = 1'b1;
		end
	end

	assign rf_wr.wr   = valid_s2 && wr_s2;
	assign rf_wr.idx  = idx_s2;
	assign rf_wr.data = wval_s2;

	assign dm_req.wr    = fire1 && st;
	assign dm_req.rd    = fire1;
	assign dm_req.addr  = eaddr[DATA_AW+1:2];
	assign dm_req.wdata = b;

	m32se_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (in_xfer),
		.rd_idx_a  (instr_word[25:21]),
		.rd_idx_b  (instr_word[20:16]),
		.wr        (rf_wr),
		.rd_data_a (rf_a),
		.rd_data_b (rf_b)
	);

	m32se_dstore u_dstore (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dm_req),
		.rdata  (dm_rdata),
		.busy   (clr_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			pc_q     <= TEXT_START;
			halt_q   <= 1'b0;
			ic_q     <= '0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (fire1) begin
				valid_s1 <= 1'b0;
			end
			if (fire1) begin
				valid_s2 <= 1'b1;
				pc_q     <= npc;
				halt_q   <= halt_nx;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				ic_q <= instruction_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			instr_s1 <= instr_word;
		end
	end

	always_ff @(posedge clk) begin
		if (fire1) begin
			npc_s2   <= npc;
			wr_s2    <= wr;
			idx_s2   <= wr ? dst : REG_ZERO;
			val_s2   <= (wr && !ld) ? val : '0;
			ld_s2    <= ld;
			st_s2    <= st;
			saddr_s2 <= st ? eaddr : '0;
			sdata_s2 <= st ? b : '0;
			halt_s2  <= halt_nx;
			bad_s2   <= bad;
		end
	end

	assign out_valid   = valid_s2;
	assign next_pc     = npc_s2;
	assign reg_written = wr_s2;
	assign reg_index   = idx_s2;
	assign reg_value   = wval_s2;
	assign store_done  = st_s2;
	assign store_addr  = saddr_s2;
	assign store_data  = sdata_s2;
	assign halted      = halt_s2;
	assign unsupported = bad_s2;

	`ASSERT_IMPLY(a_unsup_no_effect, clk, arst_n, out_valid && unsupported, !reg_written && !store_done)
	`ASSERT_IMPLY(a_no_zero_write, clk, arst_n, out_valid && reg_written, reg_index != REG_ZERO)
	`ASSERT_IMPLY(a_store_no_reg, clk, arst_n, out_valid && store_done, !reg_written)
	`ASSERT_NEXT(a_halt_sticky, clk, arst_n, halt_q, halt_q)
	`ASSERT_IMPLY(a_clear_empty_pipe, clk, arst_n, clr_busy, !valid_s1 && !valid_s2)

endmodule

@@ test/tb.sv @@
module tb;
	import m32se_pkg::*;

	localparam int HOLD_CYCLES = 80;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_CYCLES = 8;
	localparam int RANDOM_PER_PHASE = 390;
	localparam int PRINT_LIMIT = 100;

	// encodings the core does not implement
	localparam logic [5:0] OP_UNUSED = 6'h3F;
	localparam logic [5:0] FN_UNUSED = 6'd1;

	localparam logic [5:0] ALU_FNS [8] = '{FN_SLL, FN_SRL, FN_ADDU, FN_SUBU,
		FN_AND, FN_OR, FN_NOR, FN_SLTU};
	localparam logic [5:0] IMM_OPS [5] = '{OP_ADDIU, OP_SLTIU, OP_ANDI, OP_ORI, OP_LUI};

	localparam int SEND_IDLE_PCT [3] = '{35, 86, 0};
	localparam int RECV_STALL_PCT [3] = '{86, 35, 0};

	typedef struct packed {
		logic [31:0] next_pc;
		logic        reg_written;
		logic [4:0]  reg_index;
		logic [31:0] reg_value;
		logic        store_done;
		logic [31:0] store_addr;
		logic [31:0] store_data;
		logic        halted;
		logic        unsupported;
	} exec_result_t;

	typedef struct {
		logic [31:0]  word;
		bit           typed;
		exec_result_t result;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] instr_word = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] next_pc;
	logic        reg_written;
	logic [4:0]  reg_index;
	logic [31:0] reg_value;
	logic        store_done;
	logic [31:0] store_addr;
	logic [31:0] store_data;
	logic        halted;
	logic        unsupported;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] instruction_count = '0;

	// architectural state as the testbench sees it
	logic [31:0] arch_pc;
	logic [31:0] arch_regs [32];
	logic [31:0] arch_mem [DATA_WORDS];
	logic        arch_halt;
	logic [15:0] arch_count;

	exec_result_t pending_results [$];
	int error_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;
	bit hold_taken = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	directed_row_t directed_rows [28];

	mips32_subset_execute DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
			input logic [4:0] rt, input logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic logic [31:0] enc_r(input logic [4:0] rs, input logic [4:0] rt,
			input logic [4:0] rd, input logic [4:0] sh, input logic [5:0] fn);
		return {OP_SPECIAL, rs, rt, rd, sh, fn};
	endfunction

	function automatic exec_result_t wrote(input logic [31:0] pc, input logic [4:0] idx,
			input logic [31:0] val);
		exec_result_t r = '0;
		r.next_pc = pc;
		r.reg_written = 1'b1;
		r.reg_index = idx;
		r.reg_value = val;
		return r;
	endfunction

	function automatic exec_result_t stored(input logic [31:0] pc, input logic [31:0] addr,
			input logic [31:0] data);
		exec_result_t r = '0;
		r.next_pc = pc;
		r.store_done = 1'b1;
		r.store_addr = addr;
		r.store_data = data;
		return r;
	endfunction

	function automatic exec_result_t flagged(input logic [31:0] pc, input logic halt,
			input logic bad);
		exec_result_t r = '0;
		r.next_pc = pc;
		r.halted = halt;
		r.unsupported = bad;
		return r;
	endfunction

	// executes one instruction against the local state; commit=0 only peeks
	function automatic exec_result_t execute_instr(input logic [31:0] w, input bit commit);
		logic [5:0]   op, fn;
		logic [4:0]   rs, rt, rd, sh, dst;
		logic [31:0]  a, b, simm, zimm, npc, val, saddr, sdata;
		logic         wr, st, bad, hit;
		exec_result_t r;
		op = w[31:26];
		fn = w[5:0];
		rs = w[25:21];
		rt = w[20:16];
		rd = w[15:11];
		sh = w[10:6];
		zimm = {16'h0, w[15:0]};
		simm = {{16{w[15]}}, w[15:0]};
		a = arch_regs[rs];
		b = arch_regs[rt];
		npc = arch_pc + 32'd4;
		dst = rt;
		val = '0;
		saddr = '0;
		sdata = '0;
		wr = 1'b0;
		st = 1'b0;
		bad = 1'b0;
		r = '0;
		if (arch_halt) begin
			r.next_pc = arch_pc;
			r.halted = 1'b1;
			return r;
		end
		if (op == OP_SPECIAL) begin
			wr = 1'b1;
			dst = rd;
			case (fn)
				FN_AND:  val = a & b;
				FN_ADDU: val = a + b;
				FN_NOR:  val = ~(a | b);
				FN_OR:   val = a | b;
				FN_SLTU: val = (a < b) ? 32'd1 : 32'd0;
				FN_SLL:  val = b << sh;
				FN_SRL:  val = b >> sh;
				FN_SUBU: val = a - b;
				FN_JR: begin
					wr = 1'b0;
					npc = a;
				end
				default: begin
					wr = 1'b0;
					bad = 1'b1;
				end
			endcase
		end else begin
			case (op)
				OP_J: npc = {arch_pc[31:28], w[25:0], 2'b00};
				OP_JAL: begin
					wr = 1'b1;
					dst = REG_RA;
					val = arch_pc + 32'd8;
					npc = {arch_pc[31:28], w[25:0], 2'b00};
				end
				OP_ADDIU: begin
					wr = 1'b1;
					val = a + simm;
				end
				OP_ANDI: begin
					wr = 1'b1;
					val = a & zimm;
				end
				OP_ORI: begin
					wr = 1'b1;
					val = a | zimm;
				end
				OP_LUI: begin
					wr = 1'b1;
					val = {w[15:0], 16'h0};
				end
				OP_SLTIU: begin
					wr = 1'b1;
					val = (a < simm) ? 32'd1 : 32'd0;
				end
				OP_LW: begin
					wr = 1'b1;
					saddr = a + simm;
					val = arch_mem[saddr[DATA_AW+1:2]];
					saddr = '0;
				end
				OP_BEQ: if (a == b) npc = arch_pc + 32'd4 + (simm << 2);
				OP_BNE: if (a != b) npc = arch_pc + 32'd4 + (simm << 2);
				OP_SW: begin
					st = 1'b1;
					saddr = a + simm;
					sdata = b;
				end
				default: bad = 1'b1;
			endcase
		end
		// an unimplemented word leaves the registers, the memory and the pc untouched
		if (bad) begin
			npc = arch_pc;
			wr = 1'b0;
			st = 1'b0;
		end
		if (wr && dst == REG_ZERO)
			wr = 1'b0;
		hit = (npc == TEXT_START + {14'd0, arch_count, 2'b00});
		if (commit) begin
			if (wr)
				arch_regs[dst] = val;
			if (st)
				arch_mem[saddr[DATA_AW+1:2]] = sdata;
			arch_pc = npc;
			arch_halt = hit;
		end
		r.next_pc = npc;
		r.reg_written = wr;
		r.reg_index = wr ? dst : 5'd0;
		r.reg_value = wr ? val : 32'd0;
		r.store_done = st;
		r.store_addr = st ? saddr : 32'd0;
		r.store_data = st ? sdata : 32'd0;
		r.halted = hit;
		r.unsupported = bad;
		return r;
	endfunction

	// mostly a handful of registers, so back-to-back dependencies are common
	function automatic logic [4:0] pick_reg();
		if ($urandom_range(99) < 70)
			return 5'($urandom_range(7));
		return 5'($urandom_range(31));
	endfunction

	function automatic logic [31:0] pick_instr();
		int unsigned  sel;
		logic [31:0]  w;
		logic [4:0]   rs, rt, rd;
		logic [15:0]  imm;
		exec_result_t probe;
		sel = $urandom_range(99);
		rs = pick_reg();
		rt = pick_reg();
		rd = pick_reg();
		imm = 16'($urandom);
		if (sel < 4)
			w = $urandom;
		else if (sel < 8) begin
			// draw until the word is one the core rejects
			do begin
				w = $urandom;
				if (w[28])
					w[31:26] = OP_SPECIAL;
				probe = execute_instr(w, 1'b0);
			end while (!probe.unsupported);
		end else if (sel < 48)
			w = enc_r(rs, rt, rd, 5'($urandom), ALU_FNS[3'($urandom_range(7))]);
		else if (sel < 51)
			w = {OP_SPECIAL, rs, 15'($urandom), FN_JR};
		else if (sel < 55)
			w = {$urandom_range(1) ? OP_JAL : OP_J, 26'($urandom)};
		else if (sel < 65) begin
			if ($urandom_range(99) < 70)
				imm = 16'($urandom_range(15)) - 16'd8;
			w = enc_i($urandom_range(1) ? OP_BEQ : OP_BNE, rs, rt, imm);
		end else if (sel < 90)
			w = enc_i(IMM_OPS[3'($urandom_range(4))], rs, rt, imm);
		else begin
			// keep most memory traffic inside a small window so loads hit stores
			if ($urandom_range(99) < 60) begin
				rs = REG_ZERO;
				imm = {8'h0, 6'($urandom), 2'($urandom)};
			end
			w = enc_i($urandom_range(1) ? OP_LW : OP_SW, rs, rt, imm);
		end
		return w;
	endfunction

	// halting is permanent, so random traffic steers clear of the halt address
	function automatic logic [31:0] pick_running_instr();
		logic [31:0]  w;
		exec_result_t probe;
		do begin
			w = pick_instr();
			probe = execute_instr(w, 1'b0);
		end while (probe.halted);
		return w;
	endfunction

	task automatic report_error(input string what);
		error_count++;
		// keep the log readable when the design is badly broken
		if (error_count <= PRINT_LIMIT)
			$display("[%0t] %s", $time, what);
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_error($sformatf("%s: got %h, expected %h", name, got, want));
	endtask

	task automatic send_instr(input logic [31:0] w, input bit typed = 1'b0,
			input exec_result_t typed_res = '0);
		exec_result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		instr_word <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = execute_instr(w, 1'b1);
		pending_results.push_back(typed ? typed_res : predicted);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_count(input logic [15:0] value);
		cfg_valid <= 1'b1;
		instruction_count <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		arch_count = value;
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin : check_results
		exec_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0)
				report_error($sformatf("unexpected result, next_pc %h", next_pc));
			else begin
				want = pending_results.pop_front();
				compare_field("next_pc", next_pc, want.next_pc);
				compare_field("reg_written", 32'(reg_written), 32'(want.reg_written));
				compare_field("reg_index", 32'(reg_index), 32'(want.reg_index));
				compare_field("reg_value", reg_value, want.reg_value);
				compare_field("store_done", 32'(store_done), 32'(want.store_done));
				compare_field("store_addr", store_addr, want.store_addr);
				compare_field("store_data", store_data, want.store_data);
				compare_field("halted", 32'(halted), 32'(want.halted));
				compare_field("unsupported", 32'(unsupported), 32'(want.unsupported));
			end
		end
	end

	always @(posedge clk) begin : drive_out_stall
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin : watchdog
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		logic [15:0] count_setting;
		arch_pc = TEXT_START;
		arch_halt = 1'b0;
		arch_count = '0;
		foreach (arch_regs[i])
			arch_regs[i] = '0;
		foreach (arch_mem[i])
			arch_mem[i] = '0;

		directed_rows = '{
			'{enc_i(OP_LUI, REG_ZERO, 5'd1, 16'hFFFF), 1'b1,
				wrote(32'h0040_0004, 5'd1, 32'hFFFF_0000)},
			// immediate of ori is zero-extended
			'{enc_i(OP_ORI, 5'd1, 5'd1, 16'hFFFF), 1'b1,
				wrote(32'h0040_0008, 5'd1, 32'hFFFF_FFFF)},
			'{enc_i(OP_ADDIU, REG_ZERO, 5'd2, 16'h8000), 1'b1,
				wrote(32'h0040_000C, 5'd2, 32'hFFFF_8000)},
			'{enc_i(OP_ANDI, 5'd1, 5'd3, 16'h8000), 1'b1,
				wrote(32'h0040_0010, 5'd3, 32'h0000_8000)},
			'{{OP_UNUSED, 26'h3FF_FFFF}, 1'b1, flagged(32'h0040_0010, 1'b0, 1'b1)},
			'{enc_r(5'd1, 5'd1, 5'd1, 5'd0, FN_UNUSED), 1'b1,
				flagged(32'h0040_0010, 1'b0, 1'b1)},
			// writes to register zero are dropped
			'{enc_i(OP_ADDIU, 5'd1, REG_ZERO, 16'h0005), 1'b1,
				flagged(32'h0040_0014, 1'b0, 1'b0)},
			'{32'h0000_0000, 1'b1, flagged(32'h0040_0018, 1'b0, 1'b0)},
			'{enc_i(OP_SW, REG_ZERO, 5'd1, 16'h0000), 1'b1,
				stored(32'h0040_001C, 32'h0000_0000, 32'hFFFF_FFFF)},
			'{enc_i(OP_SW, REG_ZERO, 5'd2, 16'hFFFC), 1'b1,
				stored(32'h0040_0020, 32'hFFFF_FFFC, 32'hFFFF_8000)},
			// address wrap and ignored low bits
			'{enc_i(OP_LW, REG_ZERO, 5'd12, 16'hFFFC), 1'b0, '0},
			'{enc_i(OP_LW, REG_ZERO, 5'd13, 16'h1000), 1'b0, '0},
			'{enc_i(OP_LW, REG_ZERO, 5'd14, 16'h0003), 1'b0, '0},
			'{enc_r(5'd1, 5'd1, 5'd4, 5'd0, FN_ADDU), 1'b0, '0},
			'{enc_r(REG_ZERO, 5'd1, 5'd5, 5'd0, FN_SUBU), 1'b0, '0},
			'{enc_r(5'd1, 5'd2, 5'd6, 5'd0, FN_AND), 1'b0, '0},
			'{enc_r(5'd2, 5'd3, 5'd7, 5'd0, FN_OR), 1'b0, '0},
			'{enc_r(REG_ZERO, REG_ZERO, 5'd8, 5'd0, FN_NOR), 1'b0, '0},
			'{enc_r(REG_ZERO, 5'd1, 5'd9, 5'd0, FN_SLTU), 1'b0, '0},
			'{enc_i(OP_SLTIU, REG_ZERO, 5'd10, 16'hFFFF), 1'b0, '0},
			'{enc_r(REG_ZERO, 5'd1, 5'd11, 5'd31, FN_SLL), 1'b0, '0},
			'{enc_r(REG_ZERO, 5'd1, 5'd15, 5'd31, FN_SRL), 1'b0, '0},
			'{enc_i(OP_BEQ, REG_ZERO, REG_ZERO, 16'h0001), 1'b0, '0},
			'{enc_i(OP_BNE, REG_ZERO, REG_ZERO, 16'h0005), 1'b0, '0},
			// taken branch back onto itself
			'{enc_i(OP_BNE, 5'd1, REG_ZERO, 16'hFFFF), 1'b0, '0},
			'{{OP_JAL, 26'h010_0040}, 1'b0, '0},
			'{{OP_J, 26'h3FF_FFFF}, 1'b0, '0},
			'{enc_r(REG_RA, REG_ZERO, REG_ZERO, 5'd0, FN_JR), 1'b0, '0}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = SEND_IDLE_PCT[0];
		recv_stall_pct = RECV_STALL_PCT[0];
		write_count(16'hFFFF);
		foreach (directed_rows[i])
			send_instr(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].result);
		wait_for_results();

		for (int p = 0; p < 3; p++) begin
			send_idle_pct = SEND_IDLE_PCT[2'(p)];
			recv_stall_pct = RECV_STALL_PCT[2'(p)];
			case (p)
				0: count_setting = 16'($urandom_range(65534, 1));
				1: count_setting = 16'h0000;
				default: count_setting = 16'hFFFF;
			endcase
			write_count(count_setting);
			// long receiver hold-off so the pipe fills and backs up the input
			if (p == 2)
				hold_req = 1'b1;
			repeat (RANDOM_PER_PHASE)
				send_instr(pick_running_instr());
			wait_for_results();
		end

		// back to the start of text, then halt on a rejected word sitting there
		send_instr(enc_i(OP_LUI, REG_ZERO, 5'd1, 16'h0040));
		send_instr(enc_r(5'd1, REG_ZERO, REG_ZERO, 5'd0, FN_JR));
		wait_for_results();
		write_count(16'h0000);
		send_instr({OP_UNUSED, 26'($urandom)}, 1'b1, flagged(TEXT_START, 1'b1, 1'b1));
		repeat (4)
			send_instr($urandom, 1'b1, flagged(TEXT_START, 1'b1, 1'b0));
		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
